// ===== src/alm_pkg.sv =====
// Shared constants, types and register codes for the audio level meter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package alm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 16;
	localparam int LEVEL_W    = 31;
	localparam int RING_DEPTH = 1024;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int WIN_W      = RING_AW + 1;
	localparam int SQ_W       = 31;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int TOTAL_W    = SQ_W + RING_AW;
	localparam int DIV_CNT_W  = $clog2(TOTAL_W + 1);

	localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((LEVEL_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = WIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

	localparam logic MODE_PEAK = 1'b0;
	localparam logic MODE_MSQ  = 1'b1;

	// Request and write port of the ring memory.
	typedef struct packed {
		logic               we;
		logic [RING_AW-1:0] waddr;
		logic [SQ_W-1:0]    wdata;
		logic               re;
		logic [RING_AW-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] dividend;
		logic [WIN_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [TOTAL_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/alm_ring_mem.sv =====
// Single-port-write, single-port-read ring of squared samples with a registered read port.
// Depends on alm_pkg for depth, widths and the request struct.
`default_nettype none

module alm_ring_mem
	import alm_pkg::*;
(
	input  wire logic            clk,
	input  wire ram_req_t        req,
	output logic [SQ_W-1:0]      rdata
);

	logic [SQ_W-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/alm_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the mean-square level.
// Depends on alm_pkg for widths and the request and response structs.
`default_nettype none

module alm_divider
	import alm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TOTAL_W-1:0]   num_q;
	logic [WIN_W-1:0]     rem_q;
	logic [WIN_W-1:0]     den_q;

	logic [WIN_W:0]       rem_sh;
	logic [WIN_W:0]       rem_diff;
	logic                 qbit;

	// The partial remainder stays below the divisor, so it fits in the divisor width.
	always_comb begin
		rem_sh   = {rem_q, num_q[TOTAL_W-1]};
		rem_diff = rem_sh - {1'b0, den_q};
		qbit     = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(TOTAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TOTAL_W-2:0], qbit};
			rem_q <= qbit ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

`default_nettype wire

// ===== src/audio_level_meter_unit.sv =====
// Top level of the audio level meter: control sequencer, peak tracking, running sum.
// Depends on alm_pkg, alm_ring_mem and alm_divider.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------
//  s_*      | in        | tdata[15:0] sample (signed Q15)
//  m_*      | out       | tdata[30:0] level, tdata[31] zero
//  cfg_*    | in        | index 0 mode (data[0]), index 1 window_size
//
// One sample is handled at a time. Peak mode steps through accept, ring read,
// update and output load; mean-square mode also waits after the update for the
// 41-step divider that forms total / window_size.
// After reset and after every window_size write the ring is cleared, one entry
// a cycle, across all 1024 entries; s_tready stays low during that pass.
// A result waiting on a stalled m_tready holds the block in its output state.
`default_nettype none

module audio_level_meter_unit
	import alm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // [30:0] level
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]         state_q;
	logic [RING_AW-1:0] clr_cnt_q;
	logic               mode_q;
	logic [WIN_W-1:0]   win_q;
	logic [RING_AW-1:0] pos_q;
	logic [MAG_W-1:0]   run_peak_q;
	logic [MAG_W-1:0]   held_peak_q;
	logic [TOTAL_W-1:0] total_q;
	logic               m_tvalid_q;

	logic [MAG_W-1:0]     mag_q;
	logic [RING_AW-1:0]   slot_q;
	logic [SQ_W-1:0]      sq_q;
	logic [SQ_W-1:0]      old_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [SAMPLE_W-1:0] sample;
	logic [MAG_W-1:0]    mag_in;
	logic [RING_AW-1:0]  slot_in;
	logic                accept;
	logic [WIN_W-1:0]    pos_inc;
	logic                wrap;
	logic [MAG_W-1:0]    peak_max;
	logic [TOTAL_W-1:0]  total_new;
	logic [PROD_W-1:0]   prod;
	logic [WIN_W-1:0]    win_new;
	logic [LEVEL_W-1:0]  div_level;
	logic [SQ_W-1:0]     ram_rdata;
	ram_req_t            ram_req;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	alm_ring_mem u_ring (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	alm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		sample  = s_tdata[SAMPLE_W-1:0];
		// The most negative sample negates to itself, which read unsigned is its magnitude.
		mag_in  = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
		slot_in = ({1'b0, pos_q} >= win_q) ? '0 : pos_q;

		pos_inc   = {1'b0, slot_q} + 1'b1;
		wrap      = (pos_inc >= win_q);
		peak_max  = (mag_q > run_peak_q) ? mag_q : run_peak_q;
		total_new = total_q - TOTAL_W'(old_q) + TOTAL_W'(sq_q);
		prod      = mag_q * mag_q;

		if (cfg_data == '0) begin
			win_new = WIN_W'(1);
		end else if (cfg_data > CFG_DATA_W'(RING_DEPTH)) begin
			win_new = WIN_W'(RING_DEPTH);
		end else begin
			win_new = cfg_data;
		end

		if (|div_rsp.quotient[TOTAL_W-1:LEVEL_W]) begin
			div_level = '1;
		end else begin
			div_level = div_rsp.quotient[LEVEL_W-1:0];
		end
	end

	always_comb begin
		ram_req = '0;
		if (state_q == ST_CLR) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = clr_cnt_q;
		end else if (state_q == ST_UPD && mode_q == MODE_MSQ) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = slot_q;
			ram_req.wdata = sq_q;
		end
		ram_req.re    = accept;
		ram_req.raddr = slot_in;

		div_req.start    = (state_q == ST_UPD) && (mode_q == MODE_MSQ);
		div_req.dividend = total_new;
		div_req.divisor  = win_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			mode_q      <= MODE_MSQ;
			win_q       <= WIN_W'(RING_DEPTH);
			pos_q       <= '0;
			run_peak_q  <= '0;
			held_peak_q <= '0;
			total_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == RING_AW'(RING_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					pos_q <= wrap ? '0 : pos_inc[RING_AW-1:0];
					if (mode_q == MODE_PEAK) begin
						if (wrap) begin
							held_peak_q <= peak_max;
							run_peak_q  <= '0;
						end else begin
							run_peak_q <= peak_max;
						end
						state_q <= ST_OUT;
					end else begin
						total_q <= total_new;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase

			// User keeps register writes to idle or clearing; not enforced by the block.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[0];
					end
					REG_WINDOW: begin
						win_q      <= win_new;
						pos_q      <= '0;
						run_peak_q <= '0;
						total_q    <= '0;
						clr_cnt_q  <= '0;
						state_q    <= ST_CLR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag_in;
			slot_q <= slot_in;
		end
		if (state_q == ST_SQ) begin
			old_q <= ram_rdata;
			sq_q  <= prod[SQ_W-1:0];
		end
		if (state_q == ST_UPD && mode_q == MODE_PEAK) begin
			level_q <= LEVEL_W'(wrap ? peak_max : held_peak_q);
		end else if (state_q == ST_DIV && div_rsp.done) begin
			level_q <= div_level;
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= M_TDATA_W'(level_q);
		end
	end

	// Only one request is in flight at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while another is in flight");

	// The window position always lies inside the window.
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < win_q)
		else $error("window position outside the window");

	// A window write restarts the window and the ring clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_WINDOW) |=> (state_q == ST_CLR && pos_q == '0
			&& clr_cnt_q == '0 && total_q == '0))
		else $error("window write did not restart the window");

	// A quotient arrives only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// A result is presented only from the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_OUT)
		else $error("result presented outside the output state");

endmodule

`default_nettype wire
